>>> hw/rtl/bda_pkg.sv
// bda_pkg: shared constants, types and sizing functions for the
// binary to decimal ascii converter; no dependencies

package bda_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned IN_WIDTH        = 32;
  localparam int unsigned RADIX           = 10;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned CHAR_WIDTH      = 6;
  localparam int unsigned BCD_WIDTH       = 4;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_t;

  // bits of the input that take part in the conversion
  function automatic int unsigned used_width(input int unsigned w);
    return (w < IN_WIDTH) ? w : IN_WIDTH;
  endfunction

  // decimal digits of the widest value, floor(w * log10 2) + 1
  function automatic int unsigned num_digits(input int unsigned w);
    return ((used_width(w) * 1233) >> 12) + 1;
  endfunction

endpackage

>>> hw/rtl/binary_to_decimal_ascii.sv
// binary_to_decimal_ascii: top level of the binary to decimal ascii converter
// depends on bda_pkg, bda_front, bda_fifo and bda_back
//
// Each 32-bit word on the slave side becomes its decimal text, one ascii
// digit word per output, most significant digit first, leading zeros dropped
// (zero gives a single '0'); tlast marks the units digit. Only the low
// VALUE_WIDTH bits (at most 32) are converted. The shift-and-add-three
// converter takes one input bit a cycle and takes no new value until it has
// pushed the result of the last one into the queue. A two-entry queue lets
// the converter start the next value while the emitter sends the digits of
// the previous one at one per cycle as long as m_tready stays high.

module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // digit_char[5:0], zeros[7:6]
  output logic        m_tlast
);

  localparam int unsigned BW = num_digits(VALUE_WIDTH) * BCD_WIDTH;

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  logic [BW-1:0]         wr_bcd;
  logic [BW-1:0]         rd_bcd;
  logic [CHAR_WIDTH-1:0] digit_char;

  bda_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_value(s_tdata),
    .push    (push),
    .full    (full),
    .bcd_out (wr_bcd)
  );

  bda_fifo #(
    .WIDTH(BW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(wr_bcd),
    .full   (full),
    .pop    (pop),
    .rd_data(rd_bcd),
    .empty  (empty)
  );

  bda_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop      (pop),
    .bcd_in   (rd_bcd),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_char (digit_char),
    .out_last (m_tlast)
  );

  assign m_tdata = {2'b00, digit_char};

endmodule

>>> hw/rtl/bda_front.sv
// bda_front: accepts values and converts them to packed bcd, one bit a cycle
// (shift and add three); depends on bda_pkg

module bda_front
  import bda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [IN_WIDTH-1:0]                          in_value,
  output logic                                         push,
  input  logic                                         full,
  output logic [num_digits(VALUE_WIDTH)*BCD_WIDTH-1:0] bcd_out
);

  localparam int unsigned UW = used_width(VALUE_WIDTH);
  localparam int unsigned ND = num_digits(VALUE_WIDTH);
  localparam int unsigned BW = ND * BCD_WIDTH;
  localparam int unsigned CW = $clog2(UW + 1);

  front_state_t      state, state_next;
  logic [UW-1:0]     sh;
  logic [BW-1:0]     bcd;
  logic [BW-1:0]     adj;
  logic [CW-1:0]     cnt;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd[i*BCD_WIDTH +: BCD_WIDTH] >= 4'd5) begin
        adj[i*BCD_WIDTH +: BCD_WIDTH] = bcd[i*BCD_WIDTH +: BCD_WIDTH] + 4'd3;
      end else begin
        adj[i*BCD_WIDTH +: BCD_WIDTH] = bcd[i*BCD_WIDTH +: BCD_WIDTH];
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    unique case (state)
      FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = FS_CONV;
        end
      end
      FS_CONV: begin
        if (cnt == CW'(1)) begin
          state_next = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!full) begin
          push       = 1'b1;
          state_next = FS_IDLE;
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FS_IDLE && in_valid) begin
      sh  <= in_value[UW-1:0];
      bcd <= '0;
      cnt <= CW'(UW);
    end else if (state == FS_CONV) begin
      bcd <= {adj[BW-2:0], sh[UW-1]};
      sh  <= sh << 1;
      cnt <= cnt - CW'(1);
    end
  end

  assign bcd_out = bcd;

endmodule

>>> hw/rtl/bda_fifo.sv
// bda_fifo: short register queue between converter and digit emitter;
// no dependencies

module bda_fifo #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/bda_back.sv
// bda_back: takes packed bcd from the queue and emits ascii digits,
// most significant first with leading zeros dropped; depends on bda_pkg

module bda_back
  import bda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         empty,
  output logic                                         pop,
  input  logic [num_digits(VALUE_WIDTH)*BCD_WIDTH-1:0] bcd_in,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [CHAR_WIDTH-1:0]                        out_char,
  output logic                                         out_last
);

  localparam int unsigned ND = num_digits(VALUE_WIDTH);
  localparam int unsigned BW = ND * BCD_WIDTH;
  localparam int unsigned PW = $clog2(ND);

  logic             busy;
  logic [BW-1:0]    bcd;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    msd;
  logic             out_free;
  logic [BCD_WIDTH-1:0] cur;

  // highest nonzero digit, units digit when the value is zero
  always_comb begin
    msd = '0;
    for (int i = 0; i < ND; i++) begin
      if (bcd_in[i*BCD_WIDTH +: BCD_WIDTH] != '0) begin
        msd = PW'(i);
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign pop      = !busy && !empty;
  assign cur      = bcd[pos*BCD_WIDTH +: BCD_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (busy && out_free) begin
        out_valid <= 1'b1;
        if (pos == '0) begin
          busy <= 1'b0;
        end
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      out_char <= ASCII_ZERO + {{(CHAR_WIDTH-BCD_WIDTH){1'b0}}, cur};
      out_last <= (pos == '0);
      pos      <= pos - PW'(1);
    end
    if (pop) begin
      bcd <= bcd_in;
      pos <= msd;
    end
  end

endmodule
